FILE: rtl/lss_pkg.sv
package lss_pkg;

	localparam int unsigned CFG_IDX_W = 3;
	localparam int unsigned CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] REG_BRIGHTNESS = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ZERO_HIGH  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ZERO_LOW   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_ONE_HIGH   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_ONE_LOW    = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_LATCH      = 3'd5;

	localparam logic [1:0] OP_TICK  = 2'd0;
	localparam logic [1:0] OP_WRITE = 2'd1;
	localparam logic [1:0] OP_CLEAR = 2'd2;
	localparam logic [1:0] OP_START = 2'd3;

	localparam logic [1:0] PH_IDLE = 2'd0;
	localparam logic [1:0] PH_HIGH = 2'd1;
	localparam logic [1:0] PH_LOW  = 2'd2;
	localparam logic [1:0] PH_GAP  = 2'd3;

	localparam logic [4:0] BIT_TOP = 5'd23;

	typedef logic [23:0] pixel_t;

	typedef struct packed {
		logic [7:0]  brightness;
		logic [14:0] zero_high_ticks;
		logic [14:0] zero_low_ticks;
		logic [14:0] one_high_ticks;
		logic [14:0] one_low_ticks;
		logic [15:0] latch_ticks;
	} cfg_t;

	typedef struct packed {
		logic wr;
		logic clr;
	} pix_cmd_t;

	typedef struct packed {
		logic tick;
		logic start;
	} seq_cmd_t;

	typedef struct packed {
		logic busy;
		logic high;
	} line_stat_t;

	// Exact floor(c * b / 255) for 8-bit operands without a divider.
	function automatic logic [7:0] scale8(input logic [7:0] c, input logic [7:0] b);
		logic [15:0] p;
		logic [16:0] s;
		p = 16'(c) * 16'(b);
		s = 17'(p) + 17'(p[15:8]) + 17'd1;
		return s[15:8];
	endfunction

endpackage

FILE: rtl/lss_ifs.sv
interface lss_in_if import lss_pkg::*; ();
	logic        valid;
	logic        ready;
	logic [1:0]  op;
	logic [15:0] index;
	logic [7:0]  red;
	logic [7:0]  green;
	logic [7:0]  blue;
	modport source(output valid, op, index, red, green, blue, input ready);
	modport sink(input valid, op, index, red, green, blue, output ready);
endinterface

interface lss_out_if;
	logic valid;
	logic ready;
	logic line_level;
	logic busy_res;
	logic rejected;
	modport source(output valid, line_level, busy_res, rejected, input ready);
	modport sink(input valid, line_level, busy_res, rejected, output ready);
endinterface

interface lss_cfg_if import lss_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;
	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

FILE: rtl/lss_cfg_regs.sv
module lss_cfg_regs import lss_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	lss_cfg_if.sink   cfg,
	output cfg_t      regs
);

	cfg_t regs_q;

	assign cfg.ready = 1'b1;
	assign regs = regs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.brightness      <= 8'd255;
			regs_q.zero_high_ticks <= 15'd4;
			regs_q.zero_low_ticks  <= 15'd8;
			regs_q.one_high_ticks  <= 15'd8;
			regs_q.one_low_ticks   <= 15'd4;
			regs_q.latch_ticks     <= 16'd500;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				REG_BRIGHTNESS: regs_q.brightness      <= cfg.data[7:0];
				REG_ZERO_HIGH:  regs_q.zero_high_ticks <= cfg.data[14:0];
				REG_ZERO_LOW:   regs_q.zero_low_ticks  <= cfg.data[14:0];
				REG_ONE_HIGH:   regs_q.one_high_ticks  <= cfg.data[14:0];
				REG_ONE_LOW:    regs_q.one_low_ticks   <= cfg.data[14:0];
				REG_LATCH:      regs_q.latch_ticks     <= cfg.data;
				default: begin
				end
			endcase
		end
	end

endmodule

FILE: rtl/lss_pixel_store.sv
module lss_pixel_store import lss_pkg::*; #(
	parameter int LED_COUNT = 64,
	parameter int AW = 6
) (
	input  logic          clk,
	input  logic          arst_n,
	input  pix_cmd_t      cmd,
	input  logic [AW-1:0] wr_addr,
	input  logic [7:0]    red,
	input  logic [7:0]    green,
	input  logic [7:0]    blue,
	input  logic [7:0]    brightness,
	input  logic          rd_en,
	input  logic [AW-1:0] rd_addr,
	output pixel_t        rd_data,
	output pixel_t        pix0,
	output logic          clearing
);

	localparam logic [AW-1:0] LAST_ADDR = AW'(LED_COUNT - 1);

	pixel_t        mem [LED_COUNT];
	pixel_t        rd_data_q;
	pixel_t        pix0_q;
	pixel_t        wr_pixel;
	logic          clr_q;
	logic [AW-1:0] clr_addr_q;

	assign wr_pixel = {scale8(green, brightness), scale8(red, brightness),
		scale8(blue, brightness)};
	assign rd_data = rd_data_q;
	assign pix0 = pix0_q;
	assign clearing = clr_q;

	// The sweep runs once after reset and once per clear item, one entry a cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q      <= 1'b1;
			clr_addr_q <= '0;
		end else if (cmd.clr) begin
			clr_q      <= 1'b1;
			clr_addr_q <= '0;
		end else if (clr_q) begin
			if (clr_addr_q == LAST_ADDR) begin
				clr_q <= 1'b0;
			end else begin
				clr_addr_q <= clr_addr_q + 1'b1;
			end
		end
	end

	// Entry zero is mirrored so that a frame can start without a read delay.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pix0_q <= '0;
		end else if (cmd.clr) begin
			pix0_q <= '0;
		end else if (cmd.wr && wr_addr == '0) begin
			pix0_q <= wr_pixel;
		end
	end

	always_ff @(posedge clk) begin
		if (clr_q) begin
			mem[clr_addr_q] <= '0;
		end else if (cmd.wr) begin
			mem[wr_addr] <= wr_pixel;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

endmodule

FILE: rtl/lss_line_seq.sv
module lss_line_seq import lss_pkg::*; #(
	parameter int LED_COUNT = 64,
	parameter int AW = 6
) (
	input  logic          clk,
	input  logic          arst_n,
	input  seq_cmd_t      cmd,
	input  cfg_t          regs,
	input  pixel_t        pix0,
	input  pixel_t        next_pixel,
	output logic          rd_en,
	output logic [AW-1:0] rd_addr,
	output line_stat_t    stat
);

	localparam logic [AW-1:0] LAST_PTR = AW'(LED_COUNT - 1);
	localparam logic [AW:0]   COUNT_W  = (AW + 1)'(LED_COUNT);

	logic [1:0]    phase_q;
	logic [15:0]   cnt_q;
	logic [4:0]    bit_q;
	logic [AW-1:0] ptr_q;
	pixel_t        cur_q;

	logic          cur_bit;
	logic [15:0]   raw_len;
	logic [15:0]   len;
	logic [15:0]   cnt_nx;
	logic          phase_done;
	logic [AW:0]   ptr_plus2;

	assign stat.busy = (phase_q != PH_IDLE);
	assign stat.high = (phase_q == PH_HIGH);

	assign cur_bit = cur_q[bit_q];
	assign cnt_nx = cnt_q + 16'd1;
	assign ptr_plus2 = {1'b0, ptr_q} + (AW + 1)'(2);

	always_comb begin
		unique case (phase_q)
			PH_HIGH: raw_len = cur_bit ? {1'b0, regs.one_high_ticks}
				: {1'b0, regs.zero_high_ticks};
			PH_LOW:  raw_len = cur_bit ? {1'b0, regs.one_low_ticks}
				: {1'b0, regs.zero_low_ticks};
			default: raw_len = regs.latch_ticks;
		endcase
		len = (raw_len == '0) ? 16'd1 : raw_len;
	end

	assign phase_done = cmd.tick && stat.busy && (cnt_nx >= len);

	// The next pixel is fetched as soon as the current one is loaded; a pixel
	// lasts at least 48 ticks, so the read is long finished when it is needed.
	always_comb begin
		rd_en   = 1'b0;
		rd_addr = AW'(1);
		if (cmd.start) begin
			rd_en   = (LED_COUNT > 1);
			rd_addr = AW'(1);
		end else if (phase_done && phase_q == PH_LOW && bit_q == '0
			&& ptr_q != LAST_PTR) begin
			rd_en   = (ptr_plus2 < COUNT_W);
			rd_addr = ptr_plus2[AW-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			cnt_q   <= '0;
			bit_q   <= BIT_TOP;
			ptr_q   <= '0;
			cur_q   <= '0;
		end else if (cmd.start) begin
			phase_q <= PH_HIGH;
			cnt_q   <= '0;
			bit_q   <= BIT_TOP;
			ptr_q   <= '0;
			cur_q   <= pix0;
		end else if (cmd.tick && stat.busy) begin
			if (!phase_done) begin
				cnt_q <= cnt_nx;
			end else begin
				cnt_q <= '0;
				unique case (phase_q)
					PH_HIGH: phase_q <= PH_LOW;
					PH_LOW: begin
						if (bit_q != '0) begin
							bit_q   <= bit_q - 5'd1;
							phase_q <= PH_HIGH;
						end else if (ptr_q == LAST_PTR) begin
							phase_q <= PH_GAP;
						end else begin
							ptr_q   <= ptr_q + 1'b1;
							cur_q   <= next_pixel;
							bit_q   <= BIT_TOP;
							phase_q <= PH_HIGH;
						end
					end
					default: begin
						phase_q <= PH_IDLE;
						ptr_q   <= '0;
						bit_q   <= BIT_TOP;
					end
				endcase
			end
		end
	end

endmodule

FILE: rtl/rgb_led_strip_serializer_top.sv
// LED strip serializer.
// Items arrive on in_ch (op, index, red, green, blue) and each one yields exactly
// one result item on out_ch (line_level, busy_res, rejected) in the cycle after
// it is accepted. Registers are written through cfg, which is always ready.
// A tick item advances the serial line by one tick; write items scale the colour
// by brightness and store it, a start item begins a frame of LED_COUNT pixels.
// Throughput is one item per cycle for tick, write and start items. A clear item
// taken while no frame runs starts a sweep of the pixel memory, one entry per
// cycle, and no item is taken until it ends. The same sweep runs after reset
// before the first item is accepted; configuration writes are taken throughout.
// The result sits in an output register: a new item is accepted whenever that
// register is empty or being emptied in the same cycle, so a stalled receiver
// holds back input after one result has been buffered.
// The pixel memory is read one pixel ahead of the frame, through a single
// registered read port, with entry zero mirrored in a register.
module rgb_led_strip_serializer_top import lss_pkg::*; #(
	parameter int LED_COUNT = 64
) (
	input  logic      clk,
	input  logic      arst_n,
	lss_in_if.sink    in_ch,
	lss_out_if.source out_ch,
	lss_cfg_if.sink   cfg
);

	localparam int AW = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1;

	cfg_t          regs;
	pix_cmd_t      pix_cmd;
	seq_cmd_t      seq_cmd;
	line_stat_t    stat;
	pixel_t        rd_data;
	pixel_t        pix0;
	logic          clearing;
	logic          rd_en;
	logic [AW-1:0] rd_addr;
	logic          accept;
	logic          in_range;
	logic          res_level;
	logic          res_busy;
	logic          res_rej;

	logic          out_valid_q;
	logic          level_q;
	logic          busy_q;
	logic          rej_q;

	assign in_ch.ready = !clearing && (!out_valid_q || out_ch.ready);
	assign accept = in_ch.valid && in_ch.ready;
	assign in_range = {1'b0, in_ch.index} < 17'(LED_COUNT);

	assign pix_cmd.wr  = accept && in_ch.op == OP_WRITE && !stat.busy && in_range;
	assign pix_cmd.clr = accept && in_ch.op == OP_CLEAR && !stat.busy;
	assign seq_cmd.tick  = accept && in_ch.op == OP_TICK;
	assign seq_cmd.start = accept && in_ch.op == OP_START && !stat.busy;

	always_comb begin
		res_level = stat.high;
		res_busy  = stat.busy;
		res_rej   = 1'b0;
		if (in_ch.op != OP_TICK && !stat.busy) begin
			unique case (in_ch.op)
				OP_WRITE: res_rej = !in_range;
				OP_START: begin
					res_level = 1'b1;
					res_busy  = 1'b1;
				end
				default: begin
				end
			endcase
		end else if (in_ch.op != OP_TICK) begin
			res_rej = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			level_q <= res_level;
			busy_q  <= res_busy;
			rej_q   <= res_rej;
		end
	end

	assign out_ch.valid      = out_valid_q;
	assign out_ch.line_level = level_q;
	assign out_ch.busy_res   = busy_q;
	assign out_ch.rejected   = rej_q;

	lss_cfg_regs u_cfg_regs (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.regs   (regs)
	);

	lss_pixel_store #(
		.LED_COUNT (LED_COUNT),
		.AW        (AW)
	) u_pixel_store (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (pix_cmd),
		.wr_addr    (in_ch.index[AW-1:0]),
		.red        (in_ch.red),
		.green      (in_ch.green),
		.blue       (in_ch.blue),
		.brightness (regs.brightness),
		.rd_en      (rd_en),
		.rd_addr    (rd_addr),
		.rd_data    (rd_data),
		.pix0       (pix0),
		.clearing   (clearing)
	);

	lss_line_seq #(
		.LED_COUNT (LED_COUNT),
		.AW        (AW)
	) u_line_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (seq_cmd),
		.regs       (regs),
		.pix0       (pix0),
		.next_pixel (rd_data),
		.rd_en      (rd_en),
		.rd_addr    (rd_addr),
		.stat       (stat)
	);

endmodule

FILE: rtl/lss_checker.sv
module lss_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready,
	input logic line_level,
	input logic busy_res,
	input logic rejected
);

	logic in_acc;
	logic out_acc;

	assign in_acc = in_valid && in_ready;
	assign out_acc = out_valid && out_ready;

	// Every accepted item has its result waiting in the next cycle.
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> out_valid)
		else $error("accepted item produced no result");

	// A result that is taken and not replaced leaves the output empty.
	a_no_extra_result: assert property (@(posedge clk) disable iff (!arst_n)
		out_acc && !in_acc |=> !out_valid)
		else $error("result repeated or invented");

	// The line can only be high while a frame is running.
	a_high_means_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && line_level |-> busy_res)
		else $error("line high outside a frame");

	a_hold_stalled: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid
			&& $stable(line_level) && $stable(busy_res) && $stable(rejected))
		else $error("stalled result changed");

endmodule

bind rgb_led_strip_serializer_top lss_checker u_lss_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_ch.valid),
	.in_ready   (in_ch.ready),
	.out_valid  (out_ch.valid),
	.out_ready  (out_ch.ready),
	.line_level (out_ch.line_level),
	.busy_res   (out_ch.busy_res),
	.rejected   (out_ch.rejected)
);
